[design/rfat_pkg.sv]
// rfat_pkg: shared types, codes and constants of the response file argument tokenizer
// no dependencies
`default_nettype none

package rfat_pkg;

   localparam int MAX_SLASH_RUN = 255;
   localparam int SLASH_LIMIT_I = (MAX_SLASH_RUN > 255) ? 255 : MAX_SLASH_RUN;
   localparam logic [7:0] SLASH_LIMIT = 8'(SLASH_LIMIT_I);

   localparam logic [2:0] KIND_BYTE  = 3'd0;
   localparam logic [2:0] KIND_SLASH = 3'd1;
   localparam logic [2:0] KIND_ARG   = 3'd2;
   localparam logic [2:0] KIND_DONE  = 3'd3;
   localparam logic [2:0] KIND_ERR   = 3'd4;

   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_ENC    = 3'd1;
   localparam logic [2:0] ERR_NUL    = 3'd2;
   localparam logic [2:0] ERR_COUNT  = 3'd3;
   localparam logic [2:0] ERR_QUOTE  = 3'd4;
   localparam logic [2:0] ERR_SLASH  = 3'd5;

   localparam logic [1:0] MODE_UNDEC = 2'd0;
   localparam logic [1:0] MODE_PLAIN = 2'd1;
   localparam logic [1:0] MODE_UTF16 = 2'd2;

   localparam logic [7:0] BOM_FF    = 8'hff;
   localparam logic [7:0] BOM_FE    = 8'hfe;
   localparam logic [7:0] BOM_EF    = 8'hef;
   localparam logic [7:0] BOM_BB    = 8'hbb;
   localparam logic [7:0] BOM_BF    = 8'hbf;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0d;

   // element slots of a bundle: text bytes 0..3, then error, then end
   localparam logic [2:0] EL_ERR = 3'd4;
   localparam logic [2:0] EL_END = 3'd5;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [2:0] out_kind;
      logic [7:0] out_byte;
      logic [7:0] out_backslashes;
      logic [2:0] error_code;
      logic       out_last;
   } rsp_type;

   typedef struct packed {
      logic [5:0]      mask;
      logic [3:0][7:0] text;
      logic [2:0]      err;
      logic            pend;
   } bundle_type;

endpackage

`default_nettype wire

[design/rfat_front.sv]
// rfat_front: byte order mark detection, utf-16le decoding and utf-8 re-encoding
// depends on rfat_pkg
`default_nettype none

module rfat_front
   import rfat_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire req_type    req_data,
   output logic            bq_push,
   output bundle_type      bq_data,
   input  wire logic       bq_full
);

   logic [1:0]  mode_ff, mode_in;
   logic [1:0]  pfx_cnt_ff, pfx_cnt_in;
   logic [7:0]  pfx0_ff, pfx0_in;
   logic        lo_v_ff, lo_v_in;
   logic [7:0]  lo_ff, lo_in;
   logic        hs_v_ff, hs_v_in;
   logic [9:0]  hs_ff, hs_in;

   logic            accept;
   logic [7:0]      b;
   logic [15:0]     u;
   logic [20:0]     cp;
   logic [3:0][7:0] txt;
   logic [2:0]      tcnt;
   logic [2:0]      err;
   logic [3:0]      tmask;

   assign accept   = req_push && !bq_full;
   assign req_full = bq_full;
   assign b        = req_data.in_byte;
   assign u        = {b, lo_ff};
   assign cp       = 21'h10000 + 21'({hs_ff, u[9:0]});

   always_comb begin
      mode_in    = mode_ff;
      pfx_cnt_in = pfx_cnt_ff;
      pfx0_in    = pfx0_ff;
      lo_v_in    = lo_v_ff;
      lo_in      = lo_ff;
      hs_v_in    = hs_v_ff;
      hs_in      = hs_ff;
      txt        = '0;
      tcnt       = 3'd0;
      err        = ERR_NONE;
      unique case (mode_ff)
         MODE_UNDEC: begin
            case (pfx_cnt_ff)
               2'd0: begin
                  if (b == BOM_FF || b == BOM_EF) begin
                     pfx0_in    = b;
                     pfx_cnt_in = 2'd1;
                  end else begin
                     mode_in = MODE_PLAIN;
                     txt[0]  = b;
                     tcnt    = 3'd1;
                  end
               end
               2'd1: begin
                  if (pfx0_ff == BOM_FF) begin
                     pfx_cnt_in = 2'd0;
                     if (b == BOM_FE) begin
                        mode_in = MODE_UTF16;
                     end else begin
                        mode_in = MODE_PLAIN;
                        txt[0]  = BOM_FF;
                        txt[1]  = b;
                        tcnt    = 3'd2;
                     end
                  end else if (b == BOM_BB) begin
                     pfx_cnt_in = 2'd2;
                  end else begin
                     pfx_cnt_in = 2'd0;
                     mode_in    = MODE_PLAIN;
                     txt[0]     = BOM_EF;
                     txt[1]     = b;
                     tcnt       = 3'd2;
                  end
               end
               default: begin
                  pfx_cnt_in = 2'd0;
                  mode_in    = MODE_PLAIN;
                  if (b != BOM_BF) begin
                     txt[0] = BOM_EF;
                     txt[1] = BOM_BB;
                     txt[2] = b;
                     tcnt   = 3'd3;
                  end
               end
            endcase
         end
         MODE_UTF16: begin
            if (!lo_v_ff) begin
               lo_v_in = 1'b1;
               lo_in   = b;
            end else begin
               lo_v_in = 1'b0;
               if (hs_v_ff) begin
                  hs_v_in = 1'b0;
                  if (u < 16'hdc00 || u > 16'hdfff) begin
                     err = ERR_ENC;
                  end else begin
                     txt[0] = {5'b11110, cp[20:18]};
                     txt[1] = {2'b10, cp[17:12]};
                     txt[2] = {2'b10, cp[11:6]};
                     txt[3] = {2'b10, cp[5:0]};
                     tcnt   = 3'd4;
                  end
               end else if (u == 16'h0000) begin
                  err = ERR_NUL;
               end else if (u >= 16'hdc00 && u <= 16'hdfff) begin
                  err = ERR_ENC;
               end else if (u >= 16'hd800 && u <= 16'hdbff) begin
                  hs_v_in = 1'b1;
                  hs_in   = u[9:0];
               end else if (u <= 16'h007f) begin
                  txt[0] = u[7:0];
                  tcnt   = 3'd1;
               end else if (u <= 16'h07ff) begin
                  txt[0] = {3'b110, u[10:6]};
                  txt[1] = {2'b10, u[5:0]};
                  tcnt   = 3'd2;
               end else begin
                  txt[0] = {4'b1110, u[15:12]};
                  txt[1] = {2'b10, u[11:6]};
                  txt[2] = {2'b10, u[5:0]};
                  tcnt   = 3'd3;
               end
            end
         end
         default: begin
            txt[0] = b;
            tcnt   = 3'd1;
         end
      endcase
      // held mark bytes that never formed a mark go out as text
      if (req_data.in_last && mode_in == MODE_UNDEC && pfx_cnt_in != 2'd0) begin
         txt[0] = pfx0_in;
         txt[1] = BOM_BB;
         tcnt   = {1'b0, pfx_cnt_in};
      end
   end

   always_comb begin
      case (tcnt)
         3'd0:    tmask = 4'b0000;
         3'd1:    tmask = 4'b0001;
         3'd2:    tmask = 4'b0011;
         3'd3:    tmask = 4'b0111;
         default: tmask = 4'b1111;
      endcase
   end

   always_comb begin
      bq_data.mask = {req_data.in_last, err != ERR_NONE, tmask};
      bq_data.text = txt;
      bq_data.err  = err;
      bq_data.pend = (mode_in == MODE_UTF16) && (lo_v_in || hs_v_in);
   end

   assign bq_push = accept && (bq_data.mask != 6'd0);

   always_ff @(posedge clock) begin
      if (reset || (accept && req_data.in_last)) begin
         mode_ff    <= MODE_UNDEC;
         pfx_cnt_ff <= 2'd0;
         lo_v_ff    <= 1'b0;
         hs_v_ff    <= 1'b0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         pfx_cnt_ff <= pfx_cnt_in;
         lo_v_ff    <= lo_v_in;
         hs_v_ff    <= hs_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pfx0_ff <= pfx0_in;
         lo_ff   <= lo_in;
         hs_ff   <= hs_in;
      end
   end

endmodule

`default_nettype wire

[design/rfat_bundle_q.sv]
// rfat_bundle_q: two-entry queue of decoded bundles between front and back
// depends on rfat_pkg
`default_nettype none

module rfat_bundle_q
   import rfat_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire bundle_type push_data,
   output logic            full,
   input  wire logic       pop,
   output logic            valid,
   output bundle_type      pop_data
);

   bundle_type  ent_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  cnt_ff;
   logic        do_push;
   logic        do_pop;

   assign full     = (cnt_ff == 2'd2);
   assign valid    = (cnt_ff != 2'd0);
   assign pop_data = ent_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         cnt_ff <= cnt_ff + 2'(do_push) - 2'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) ent_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

[design/rfat_back.sv]
// rfat_back: argument splitter, one bundle element a cycle, result hold and output queue
// depends on rfat_pkg; a full output queue with a result held stalls the splitter
`default_nettype none

module rfat_back
   import rfat_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        bq_valid,
   input  wire bundle_type  bq_data,
   output logic             bq_pop,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output rsp_type          rsp_data
);

   logic [15:0] max_args_ff;
   logic        failed_ff, failed_in;
   logic        quote_ff, quote_in;
   logic [7:0]  slash_ff, slash_in;
   logic        tok_ff, tok_in;
   logic [15:0] args_ff, args_in;
   logic [5:0]  done_ff;
   logic        hold_v_ff;
   logic        hold_closed_ff;
   rsp_type     hold_ff;
   rsp_type     ent_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  cnt_ff;

   logic [5:0]  pending;
   logic [2:0]  sel;
   logic [5:0]  cur_bit;
   logic [7:0]  c;
   logic        ws;
   logic        ofull;
   logic        proceed;
   logic        res_v;
   rsp_type     res;
   logic        elem_done;
   logic        bundle_done;
   logic        new_res;
   logic        hold_wr;
   logic        do_pop;
   rsp_type     wr_ent;

   assign pending = bq_data.mask & ~done_ff;

   always_comb begin
      sel = EL_END;
      for (int i = 5; i >= 0; i--) begin
         if (pending[i]) sel = 3'(i);
      end
   end

   assign cur_bit = 6'd1 << sel;
   assign c       = bq_data.text[sel[1:0]];
   assign ws      = !quote_ff && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR));
   assign ofull   = (cnt_ff == 2'd2);
   assign proceed = bq_valid && (!hold_v_ff || !ofull);

   always_comb begin
      failed_in = failed_ff;
      quote_in  = quote_ff;
      slash_in  = slash_ff;
      tok_in    = tok_ff;
      args_in   = args_ff;
      res       = '0;
      res_v     = 1'b0;
      elem_done = 1'b1;
      if (failed_ff) begin
         elem_done = 1'b1;
      end else if (sel == EL_END) begin
         if (bq_data.pend) begin
            res_v = 1'b1; res.out_kind = KIND_ERR; res.error_code = ERR_ENC;
            failed_in = 1'b1;
         end else if (slash_ff != 8'd0) begin
            res_v = 1'b1; res.out_kind = KIND_SLASH; res.out_backslashes = slash_ff;
            tok_in = 1'b1; slash_in = 8'd0; elem_done = 1'b0;
         end else if (quote_ff) begin
            res_v = 1'b1; res.out_kind = KIND_ERR; res.error_code = ERR_QUOTE;
            failed_in = 1'b1;
         end else if (tok_ff) begin
            tok_in = 1'b0;
            res_v  = 1'b1;
            if (args_ff >= max_args_ff) begin
               res.out_kind = KIND_ERR; res.error_code = ERR_COUNT;
               failed_in = 1'b1;
            end else begin
               res.out_kind = KIND_ARG;
               args_in = args_ff + 16'd1;
               elem_done = 1'b0;
            end
         end else begin
            res_v = 1'b1; res.out_kind = KIND_DONE;
         end
      end else if (sel == EL_ERR) begin
         res_v = 1'b1; res.out_kind = KIND_ERR; res.error_code = bq_data.err;
         failed_in = 1'b1;
      end else if (c == 8'd0) begin
         res_v = 1'b1; res.out_kind = KIND_ERR; res.error_code = ERR_NUL;
         failed_in = 1'b1;
      end else if (c == CH_BSLASH) begin
         if (slash_ff >= SLASH_LIMIT) begin
            res_v = 1'b1; res.out_kind = KIND_ERR; res.error_code = ERR_SLASH;
            failed_in = 1'b1;
         end else begin
            slash_in = slash_ff + 8'd1;
         end
      end else if (c == CH_QUOTE) begin
         slash_in = 8'd0;
         if (slash_ff[0]) begin
            res_v = 1'b1; res.out_kind = KIND_BYTE; res.out_byte = CH_QUOTE;
            res.out_backslashes = slash_ff >> 1;
            tok_in = 1'b1;
         end else begin
            if (slash_ff[7:1] != 7'd0) begin
               res_v = 1'b1; res.out_kind = KIND_SLASH;
               res.out_backslashes = slash_ff >> 1;
               tok_in = 1'b1;
            end
            quote_in = !quote_ff;
         end
      end else if (ws) begin
         if (slash_ff != 8'd0) begin
            res_v = 1'b1; res.out_kind = KIND_SLASH; res.out_backslashes = slash_ff;
            tok_in = 1'b1; slash_in = 8'd0; elem_done = 1'b0;
         end else if (tok_ff) begin
            tok_in = 1'b0;
            res_v  = 1'b1;
            if (args_ff >= max_args_ff) begin
               res.out_kind = KIND_ERR; res.error_code = ERR_COUNT;
               failed_in = 1'b1;
            end else begin
               res.out_kind = KIND_ARG;
               args_in = args_ff + 16'd1;
            end
         end
      end else begin
         res_v = 1'b1; res.out_kind = KIND_BYTE; res.out_byte = c;
         res.out_backslashes = slash_ff;
         slash_in = 8'd0; tok_in = 1'b1;
      end
   end

   assign bundle_done = elem_done && ((pending & ~cur_bit) == 6'd0);
   assign bq_pop      = proceed && bundle_done;
   assign new_res     = proceed && res_v;
   assign hold_wr     = hold_v_ff && !ofull && (hold_closed_ff || new_res);
   assign do_pop      = rsp_pop && !rsp_empty;
   assign rsp_empty   = (cnt_ff == 2'd0);
   assign rsp_data    = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ent          = hold_ff;
      wr_ent.out_last = hold_closed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_args_ff <= 16'hffff;
      end else if (csr_we) begin
         max_args_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (proceed && elem_done && sel == EL_END)) begin
         failed_ff <= 1'b0;
         quote_ff  <= 1'b0;
         slash_ff  <= 8'd0;
         tok_ff    <= 1'b0;
         args_ff   <= 16'd0;
      end else if (proceed) begin
         failed_ff <= failed_in;
         quote_ff  <= quote_in;
         slash_ff  <= slash_in;
         tok_ff    <= tok_in;
         args_ff   <= args_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff        <= 6'd0;
         hold_v_ff      <= 1'b0;
         hold_closed_ff <= 1'b0;
      end else begin
         if (bq_pop) begin
            done_ff <= 6'd0;
         end else if (proceed && elem_done) begin
            done_ff <= done_ff | cur_bit;
         end
         if (new_res) begin
            hold_v_ff      <= 1'b1;
            hold_closed_ff <= bundle_done;
         end else if (hold_wr) begin
            hold_v_ff      <= 1'b0;
            hold_closed_ff <= 1'b0;
         end else if (bq_pop && hold_v_ff) begin
            hold_closed_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (new_res) hold_ff <= res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (hold_wr) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         cnt_ff <= cnt_ff + 2'(hold_wr) - 2'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (hold_wr) ent_ff[wr_ptr_ff] <= wr_ent;
   end

endmodule

`default_nettype wire

[design/response_file_argument_tokenizer.sv]
// response_file_argument_tokenizer: top level, front decoder, bundle queue and splitter
// depends on rfat_pkg, rfat_front, rfat_bundle_q, rfat_back
//
//   channel   ports                          transaction
//   request   req_push  req_full  req_data   one raw byte with last flag
//   response  rsp_empty rsp_pop   rsp_data   one result item
//   csr       csr_we    csr_wdata            max_args write
//
// a byte is taken every cycle while the bundle queue has room
// the back end works at most one decoded element per cycle while not stalled; a utf-16
//   unit that expands to n utf-8 bytes gives n elements, and an element that also
//   flushes a backslash run or closes an argument stays until each result is made
// a byte's results pass the bundle queue, the hold register and the response queue
// reset is synchronous and clears all message state and both queues
// a full response queue with a result held stalls the back end, a full bundle queue raises req_full
`default_nettype none

module response_file_argument_tokenizer
   import rfat_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire req_type     req_data,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);

   logic       bq_push;
   logic       bq_full;
   logic       bq_valid;
   logic       bq_pop;
   bundle_type bq_wdata;
   bundle_type bq_rdata;

   rfat_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .bq_push  (bq_push),
      .bq_data  (bq_wdata),
      .bq_full  (bq_full)
   );

   rfat_bundle_q u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (bq_push),
      .push_data (bq_wdata),
      .full      (bq_full),
      .pop       (bq_pop),
      .valid     (bq_valid),
      .pop_data  (bq_rdata)
   );

   rfat_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .bq_valid  (bq_valid),
      .bq_data   (bq_rdata),
      .bq_pop    (bq_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[design/rfat_checker.sv]
// rfat_checker: port-level assertions for the tokenizer, bound to the top level
// depends on rfat_pkg and response_file_argument_tokenizer
`default_nettype none

module rfat_checker
   import rfat_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_empty,
   input wire logic    rsp_pop,
   input wire rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response queue not empty after reset");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_data.out_kind == KIND_ERR) == (rsp_data.error_code != ERR_NONE)))
      else $error("error code does not match result kind");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.out_kind == KIND_DONE) |-> rsp_data.out_last)
      else $error("message done is not the last result of its transaction");

   a_no_nul: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.out_kind == KIND_BYTE) |-> (rsp_data.out_byte != 8'd0))
      else $error("nul byte passed into an argument");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind response_file_argument_tokenizer rfat_checker u_rfat_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

`default_nettype wire

[verif/tb.sv]
// tb: self-checking testbench of the response file argument tokenizer
// drives raw message bytes, predicts result transactions and checks them in order
// depends on rfat_pkg and response_file_argument_tokenizer
`timescale 1ns / 100ps

module tb;
   import rfat_pkg::*;

   class token_scoreboard;
      rsp_type     pending[$];
      int          errors;
      logic [15:0] max_args;
      logic [1:0]  mode;
      logic [7:0]  mark0, mark1;
      int          mark_cnt;
      logic [8:0]  held_low;
      logic [10:0] held_high;
      bit          quoted, tok_open, dead;
      int          slashes, argc;
      rsp_type     step_out[$];

      function new();
         errors = 0;
         max_args = 16'hffff;
         clear_msg();
      endfunction

      function void clear_msg();
         mode = MODE_UNDEC; mark0 = '0; mark1 = '0; mark_cnt = 0;
         held_low = '0; held_high = '0; quoted = 0; tok_open = 0;
         dead = 0; slashes = 0; argc = 0;
      endfunction

      function void emit(logic [2:0] k, logic [7:0] b, logic [7:0] bs, logic [2:0] e);
         rsp_type r;
         if (step_out.size() >= 8) return;
         r.out_kind = k; r.out_byte = b; r.out_backslashes = bs;
         r.error_code = e; r.out_last = 1'b0;
         step_out = {step_out, r};
      endfunction

      function void raise(logic [2:0] e);
         emit(KIND_ERR, 8'd0, 8'd0, e);
         dead = 1;
      endfunction

      function void end_token();
         if (!tok_open) return;
         tok_open = 0;
         if (argc >= max_args) begin
            raise(ERR_COUNT);
            return;
         end
         argc++;
         emit(KIND_ARG, 8'd0, 8'd0, ERR_NONE);
      endfunction

      function void text(logic [7:0] c);
         if (dead) return;
         if (c == 0) begin
            raise(ERR_NUL);
         end else if (c == CH_BSLASH) begin
            if (slashes >= SLASH_LIMIT) raise(ERR_SLASH);
            else slashes++;
         end else if (c == CH_QUOTE) begin
            if (slashes % 2) begin
               emit(KIND_BYTE, CH_QUOTE, 8'(slashes / 2), ERR_NONE);
               tok_open = 1;
            end else begin
               if (slashes / 2 != 0) begin
                  emit(KIND_SLASH, 8'd0, 8'(slashes / 2), ERR_NONE);
                  tok_open = 1;
               end
               quoted = !quoted;
            end
            slashes = 0;
         end else if (!quoted && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
            if (slashes != 0) begin
               emit(KIND_SLASH, 8'd0, 8'(slashes), ERR_NONE);
               tok_open = 1;
               slashes = 0;
            end
            end_token();
         end else begin
            emit(KIND_BYTE, c, 8'(slashes), ERR_NONE);
            slashes = 0;
            tok_open = 1;
         end
      endfunction

      function void point(int unsigned cp);
         if (cp <= 'h7f) text(8'(cp));
         else if (cp <= 'h7ff) begin
            text(8'('hc0 | (cp >> 6))); text(8'('h80 | (cp & 'h3f)));
         end else if (cp <= 'hffff) begin
            text(8'('he0 | (cp >> 12))); text(8'('h80 | ((cp >> 6) & 'h3f)));
            text(8'('h80 | (cp & 'h3f)));
         end else begin
            text(8'('hf0 | ((cp >> 18) & 7))); text(8'('h80 | ((cp >> 12) & 'h3f)));
            text(8'('h80 | ((cp >> 6) & 'h3f))); text(8'('h80 | (cp & 'h3f)));
         end
      endfunction

      function void unit16(int unsigned u);
         int unsigned hi;
         if (held_high[10]) begin
            hi = held_high[9:0];
            held_high = '0;
            if (u < 'hdc00 || u > 'hdfff) raise(ERR_ENC);
            else point('h10000 + (hi << 10) + (u - 'hdc00));
         end else if (u == 0) raise(ERR_NUL);
         else if (u >= 'hdc00 && u <= 'hdfff) raise(ERR_ENC);
         else if (u >= 'hd800 && u <= 'hdbff) held_high = 11'('h400 | (u - 'hd800));
         else point(u);
      endfunction

      function void undecided(logic [7:0] b);
         if (mark_cnt == 0) begin
            if (b == BOM_FF || b == BOM_EF) begin
               mark0 = b; mark_cnt = 1;
            end else begin
               mode = MODE_PLAIN; text(b);
            end
         end else if (mark_cnt == 1 && mark0 == BOM_FF) begin
            mark_cnt = 0;
            if (b == BOM_FE) mode = MODE_UTF16;
            else begin
               mode = MODE_PLAIN; text(BOM_FF); text(b);
            end
         end else if (mark_cnt == 1) begin
            if (b == BOM_BB) begin
               mark1 = b; mark_cnt = 2;
            end else begin
               mark_cnt = 0; mode = MODE_PLAIN; text(BOM_EF); text(b);
            end
         end else begin
            mark_cnt = 0; mode = MODE_PLAIN;
            if (b != BOM_BF) begin
               text(BOM_EF); text(BOM_BB); text(b);
            end
         end
      endfunction

      function void finish_msg();
         if (mode == MODE_UNDEC) begin
            mode = MODE_PLAIN;
            if (mark_cnt > 0) text(mark0);
            if (mark_cnt > 1) text(mark1);
            mark_cnt = 0;
         end
         if (dead) return;
         if (mode == MODE_UTF16 && (held_low[8] || held_high[10])) begin
            raise(ERR_ENC);
            return;
         end
         if (slashes != 0) begin
            emit(KIND_SLASH, 8'd0, 8'(slashes), ERR_NONE);
            tok_open = 1; slashes = 0;
         end
         if (quoted) begin
            raise(ERR_QUOTE);
            return;
         end
         end_token();
         if (dead) return;
         emit(KIND_DONE, 8'd0, 8'd0, ERR_NONE);
      endfunction

      // note an accepted input transaction, queue its results
      function void note_input(req_type t);
         step_out.delete();
         if (!dead) begin
            if (mode == MODE_UNDEC) undecided(t.in_byte);
            else if (mode == MODE_UTF16) begin
               if (!held_low[8]) held_low = {1'b1, t.in_byte};
               else begin
                  int unsigned u;
                  u = {t.in_byte, held_low[7:0]};
                  held_low = '0;
                  unit16(u);
               end
            end else text(t.in_byte);
         end
         if (t.in_last) begin
            if (!dead) finish_msg();
            clear_msg();
         end
         if (step_out.size() > 0) step_out[step_out.size() - 1].out_last = 1'b1;
         foreach (step_out[i]) pending = {pending, step_out[i]};
      endfunction

      function void check_result(rsp_type r);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected transaction kind %0d", r.out_kind);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (r.out_kind !== e.out_kind) begin
            $error("out_kind exp %0d got %0d", e.out_kind, r.out_kind); errors++;
         end
         if (r.out_byte !== e.out_byte) begin
            $error("out_byte exp %0h got %0h", e.out_byte, r.out_byte); errors++;
         end
         if (r.out_backslashes !== e.out_backslashes) begin
            $error("out_backslashes exp %0d got %0d", e.out_backslashes,
                   r.out_backslashes);
            errors++;
         end
         if (r.error_code !== e.error_code) begin
            $error("error_code exp %0d got %0d", e.error_code, r.error_code); errors++;
         end
         if (r.out_last !== e.out_last) begin
            $error("out_last exp %0d got %0d", e.out_last, r.out_last); errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_push = 0;
   logic        req_full;
   req_type     req_data = '0;
   logic        rsp_empty;
   logic        rsp_pop = 0;
   rsp_type     rsp_data;
   logic        csr_we = 0;
   logic [15:0] csr_wdata = 0;

   token_scoreboard sb = new();
   int  cycles = 0;
   int  sent = 0;

   response_file_argument_tokenizer dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("tb: errors");
         $finish;
      end
      if (!reset && rsp_pop && !rsp_empty) sb.check_result(rsp_data);
   end

   function int gap_len();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // receiver stalls; some stretches pop every cycle
   initial begin
      int g;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 3) == 0) begin
            rsp_pop <= 1;
            repeat ($urandom_range(20, 80)) @(negedge clock);
         end else begin
            g = gap_len();
            if (g > 0) begin
               rsp_pop <= 0;
               repeat (g) @(negedge clock);
            end
            rsp_pop <= 1;
            @(negedge clock);
         end
      end
   end

   bit burst_mode = 0;

   task automatic send(logic [7:0] b, bit lst);
      int g;
      g = burst_mode ? 0 : gap_len();
      if (g > 0) begin
         req_push <= 0;
         repeat (g) @(negedge clock);
      end
      req_push <= 1;
      req_data <= '{in_byte: b, in_last: lst};
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_input('{in_byte: b, in_last: lst});
      sent++;
      @(negedge clock);
   endtask

   task automatic send_msg(logic [7:0] m[$]);
      foreach (m[i]) send(m[i], i == m.size() - 1);
   endtask

   task automatic drain();
      req_push <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_max(logic [15:0] v);
      drain();
      csr_we <= 1;
      csr_wdata <= v;
      sb.max_args = v;
      @(negedge clock);
      csr_we <= 0;
   endtask

   function logic [7:0] pick_char();
      case ($urandom_range(0, 9))
         0, 1: return CH_BSLASH;
         2: return CH_QUOTE;
         3: return CH_SPACE;
         4: return 8'($urandom_range(9, 13));
         5: return 8'($urandom_range(0, 255));
         default: return 8'($urandom_range(33, 126));
      endcase
   endfunction

   task automatic random_msg();
      logic [7:0] m[$];
      int n, k;
      int unsigned u;
      n = $urandom_range(1, 12);
      k = $urandom_range(0, 9);
      if (k < 3) begin
         m = {m, BOM_FF, BOM_FE};
         repeat (n) begin
            case ($urandom_range(0, 9))
               0: u = $urandom_range('hd800, 'hdbff);
               1: u = $urandom_range('hdc00, 'hdfff);
               2: u = $urandom_range(0, 'hffff);
               default: u = pick_char();
            endcase
            if (u >= 'hd800 && u <= 'hdbff && $urandom_range(0, 3) != 0) begin
               m = {m, 8'(u), 8'(u >> 8)};
               u = $urandom_range('hdc00, 'hdfff);
            end
            if (u == 0 && $urandom_range(0, 3) != 0) u = 'h41;
            m = {m, 8'(u), 8'(u >> 8)};
         end
         if ($urandom_range(0, 9) == 0) void'(m.pop_back());
      end else begin
         if (k == 3) begin
            m = {m, BOM_EF, BOM_BB, BOM_BF};
         end else if (k == 4) m = {m, BOM_EF};
         repeat (n) begin
            m = {m, pick_char()};
            if (m[m.size() - 1] == 0 && $urandom_range(0, 3) != 0)
               m[m.size() - 1] = 8'h61;
         end
      end
      send_msg(m);
   endtask

   initial begin
      int base;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      set_max(16'hffff);
      // directed: marks, quoting, errors
      send_msg('{8'h61, 8'h20, 8'h5c, 8'h5c, 8'h5c, 8'h22, 8'h62, 8'h09, 8'h0d});
      send_msg('{8'h22, 8'h61, 8'h20, 8'h62, 8'h22, 8'h5c, 8'h5c, 8'h22, 8'h5c});
      send_msg('{8'hff, 8'hfe, 8'h3d, 8'hd8, 8'h00, 8'hde, 8'he9, 8'h00, 8'h41});
      send_msg('{8'hff, 8'hfe, 8'h00, 8'hdc, 8'h41, 8'h00});
      send_msg('{8'hff, 8'hfe, 8'h00, 8'hd8, 8'h00, 8'h00});
      send_msg('{8'hef, 8'hbb, 8'hbf, 8'h7f, 8'h00, 8'h61});
      send_msg('{8'hef, 8'hbb});
      send_msg('{8'hff});
      send_msg('{8'hff, 8'h41});
      send_msg('{8'h22, 8'h61});
      send_msg('{8'hef, 8'h20, 8'hbb, 8'h80});
      send_msg('{8'hef, 8'hbb, 8'h61, 8'h5c});
      send_msg('{8'hff, 8'hfe, 8'hff, 8'hff, 8'h20, 8'h00, 8'hff, 8'h07});
      set_max(16'd0);
      send_msg('{8'h61, 8'h20, 8'h62});
      set_max(16'd1);
      send_msg('{8'h61, 8'h20, 8'h62, 8'hff, 8'hfe});
      // backslash run overflow
      begin
         logic [7:0] m[$];
         repeat (256) m = {m, CH_BSLASH};
         m = {m, 8'h61};
         set_max(16'hffff);
         send_msg(m);
      end
      // hold-off: wait for all results before continuing
      drain();
      base = sent;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: set_max(16'hffff);
            1: set_max(16'd2);
            2: set_max(16'($urandom_range(0, 65535)));
            default: set_max(16'd3);
         endcase
         burst_mode = (ph == 2);
         while (sent < base + 12 * (ph + 1)) random_msg();
      end
      burst_mode = 0;
      drain();
      repeat (50) @(negedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end
endmodule
